[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

[design/tadsr_pkg.sv]
// ----------------------------------------------------------------------------
// tadsr_pkg
// Types and constants shared by the timed ADSR envelope modules.
// ----------------------------------------------------------------------------
package tadsr_pkg;

	localparam int unsigned PH_W      = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned TICK_W    = 8;

	localparam logic [PH_W-1:0] PH_OFF     = 3'd0;
	localparam logic [PH_W-1:0] PH_ATTACK  = 3'd1;
	localparam logic [PH_W-1:0] PH_DECAY   = 3'd2;
	localparam logic [PH_W-1:0] PH_SUSTAIN = 3'd3;
	localparam logic [PH_W-1:0] PH_RELEASE = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_LEN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_LEVEL  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_LEVEL  = 3'd5;

	localparam int unsigned RST_LENGTH = 100;
	localparam int unsigned RST_PEAK   = 65535;
	localparam int unsigned RST_HOLD   = 32768;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[design/tadsr_div.sv]
// ----------------------------------------------------------------------------
// tadsr_div
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tadsr_div
	import tadsr_pkg::*;
#(
	parameter int unsigned NW = 32,
	parameter int unsigned DW = 16,
	parameter int unsigned QW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output div_stat_t     stat,
	output logic [QW-1:0] quot
);

	localparam int unsigned CW = $clog2(QW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [QW-1:0] lo_q;
	logic [DW-1:0] den_q;

	logic [DW:0]   trial;
	logic          qbit;
	logic [DW-1:0] rem_nxt;

	// The caller guarantees the quotient fits in QW bits, so the upper
	// numerator bits are already below the divisor when loaded.
	always_comb begin
		trial   = {rem_q, lo_q[QW-1]};
		qbit    = (trial >= {1'b0, den_q});
		rem_nxt = qbit ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[NW-1:QW];
			lo_q  <= num[QW-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			lo_q  <= {lo_q[QW-2:0], qbit};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = (den_q == '0) ? '0 : lo_q;

	`ASSERT_CLK(a_start_when_free, start |-> !busy_q, "divider started while busy")
	`ASSERT_CLK(a_done_ends_run, done_q |-> ($past(busy_q) && !busy_q), "stray divider done")

endmodule

[design/timed_adsr_envelope.sv]
// ----------------------------------------------------------------------------
// timed_adsr_envelope
// Linear attack, decay, timed sustain and release envelope generator.
// ----------------------------------------------------------------------------
// A request with tuser high restarts the attack phase; a request with tuser
// low carries the ticks elapsed since the last request. Every request yields
// one result holding the level and the phase. A trigger, or a tick while the
// envelope is off, goes from the idle state straight to the output step. Any
// other tick that leaves the envelope in sustain or off passes through the
// multiply step before the output step. A tick that leaves it in attack,
// decay or release also waits in the divide step for the shared divider,
// which retires one quotient bit per cycle. A result that is not taken holds
// the block in its output step until the output register is free. The output
// register lets the block take the next request while a result still waits.
`include "assert_macros.svh"

module timed_adsr_envelope
	import tadsr_pkg::*;
#(
	parameter int unsigned LEVEL_BITS = 16,
	parameter int unsigned TIME_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [TICK_W-1:0]     s_tdata,    // tick_count
	input  logic                  s_tuser,    // req_type
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// level, stage, zero fill
	output logic [((LEVEL_BITS + PH_W + 7) / 8) * 8 - 1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [((TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS)-1:0] cfg_data
);

	localparam int unsigned OUT_W = ((LEVEL_BITS + PH_W + 7) / 8) * 8;
	localparam int unsigned NW    = LEVEL_BITS + TIME_BITS;

	logic [TIME_BITS-1:0]  attack_len_q;
	logic [TIME_BITS-1:0]  decay_len_q;
	logic [TIME_BITS-1:0]  sustain_len_q;
	logic [TIME_BITS-1:0]  release_len_q;
	logic [LEVEL_BITS-1:0] peak_q;
	logic [LEVEL_BITS-1:0] hold_q;

	state_t                state_q;
	logic [PH_W-1:0]       phase_q;
	logic [TIME_BITS-1:0]  timer_q;
	logic [LEVEL_BITS-1:0] amp_q;
	logic                  m_tvalid_q;
	logic [OUT_W-1:0]      m_tdata_q;

	logic [LEVEL_BITS-1:0] hold_eff;
	logic [TIME_BITS-1:0]  len_sel;
	logic [LEVEL_BITS-1:0] end_sel;
	logic [PH_W-1:0]       phase_nxt;
	logic [TIME_BITS:0]    sum;
	logic [TIME_BITS-1:0]  timer_sat;
	logic                  interp;
	logic                  sub_sel;
	logic [LEVEL_BITS-1:0] mul_a;
	logic [LEVEL_BITS-1:0] base_sel;
	logic [NW-1:0]         prod;
	logic                  s_acc;
	logic                  out_free;
	logic                  out_load;
	logic                  div_start;
	div_stat_t             div_stat;
	logic [LEVEL_BITS-1:0] quot;

	assign hold_eff = (hold_q > peak_q) ? peak_q : hold_q;

	// Length, end level and operands all follow the registered phase.
	always_comb begin
		len_sel   = '0;
		end_sel   = '0;
		phase_nxt = PH_OFF;
		interp    = 1'b0;
		sub_sel   = 1'b0;
		mul_a     = '0;
		base_sel  = '0;
		case (phase_q)
			PH_ATTACK: begin
				len_sel   = attack_len_q;
				end_sel   = peak_q;
				phase_nxt = PH_DECAY;
				interp    = 1'b1;
				mul_a     = peak_q;
			end
			PH_DECAY: begin
				len_sel   = decay_len_q;
				end_sel   = hold_eff;
				phase_nxt = PH_SUSTAIN;
				interp    = 1'b1;
				sub_sel   = 1'b1;
				mul_a     = peak_q - hold_eff;
				base_sel  = peak_q;
			end
			PH_SUSTAIN: begin
				len_sel   = sustain_len_q;
				end_sel   = hold_eff;
				phase_nxt = PH_RELEASE;
			end
			PH_RELEASE: begin
				len_sel   = release_len_q;
				phase_nxt = PH_OFF;
				interp    = 1'b1;
				sub_sel   = 1'b1;
				mul_a     = hold_eff;
				base_sel  = hold_eff;
			end
			default: begin
				phase_nxt = PH_OFF;
			end
		endcase
	end

	assign sum       = {1'b0, timer_q} + (TIME_BITS + 1)'(s_tdata);
	assign timer_sat = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
	assign prod      = NW'(mul_a) * NW'(timer_q);

	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign out_load  = (state_q == ST_OUT) && out_free;
	assign div_start = (state_q == ST_MUL) && interp;

	tadsr_div #(
		.NW (NW),
		.DW (TIME_BITS),
		.QW (LEVEL_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod),
		.den    (len_sel),
		.stat   (div_stat),
		.quot   (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_len_q  <= TIME_BITS'(RST_LENGTH);
			decay_len_q   <= TIME_BITS'(RST_LENGTH);
			sustain_len_q <= TIME_BITS'(RST_LENGTH);
			release_len_q <= TIME_BITS'(RST_LENGTH);
			peak_q        <= LEVEL_BITS'(RST_PEAK);
			hold_q        <= LEVEL_BITS'(RST_HOLD);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ATTACK_LEN:  attack_len_q  <= cfg_data[TIME_BITS-1:0];
				REG_DECAY_LEN:   decay_len_q   <= cfg_data[TIME_BITS-1:0];
				REG_SUSTAIN_LEN: sustain_len_q <= cfg_data[TIME_BITS-1:0];
				REG_RELEASE_LEN: release_len_q <= cfg_data[TIME_BITS-1:0];
				REG_PEAK_LEVEL:  peak_q        <= cfg_data[LEVEL_BITS-1:0];
				REG_HOLD_LEVEL:  hold_q        <= cfg_data[LEVEL_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= PH_OFF;
			timer_q    <= '0;
			amp_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (s_tuser) begin
							phase_q <= PH_ATTACK;
							timer_q <= '0;
							state_q <= ST_OUT;
						end else if (phase_q == PH_OFF) begin
							state_q <= ST_OUT;
						end else begin
							if (timer_sat >= len_sel) begin
								amp_q   <= end_sel;
								phase_q <= phase_nxt;
								timer_q <= '0;
							end else begin
								timer_q <= timer_sat;
							end
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= interp ? ST_DIV : ST_OUT;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						amp_q   <= sub_sel ? base_sel - quot : base_sel + quot;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			m_tdata_q <= OUT_W'({phase_q, amp_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`ASSERT_CLK(a_div_done_in_div, div_stat.done |-> (state_q == ST_DIV), "divider done outside divide state")
	`ASSERT_CLK(a_trigger_attack, (s_tvalid && s_tready && s_tuser) |=> (phase_q == PH_ATTACK), "trigger did not restart attack")
	`ASSERT_NEVER(a_phase_range, phase_q > PH_RELEASE, "phase out of range")

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// timed_adsr_envelope testbench
// Streams trigger and tick requests into the envelope generator under several
// register settings and flow-control mixes. A behavioral envelope model
// predicts the level and phase of every request, and each result is checked
// in order against it.
// ----------------------------------------------------------------------------
module testbench
	import tadsr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LVL_W = 16;
	localparam int unsigned OUT_W = ((LVL_W + PH_W + 7) / 8) * 8;
	localparam int unsigned WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic [PH_W-1:0]  stage;
	} env_point_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [TICK_W-1:0]    s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	logic [15:0] attack_len = 16'(RST_LENGTH);
	logic [15:0] decay_len = 16'(RST_LENGTH);
	logic [15:0] sustain_len = 16'(RST_LENGTH);
	logic [15:0] release_len = 16'(RST_LENGTH);
	logic [15:0] peak_lvl = 16'(RST_PEAK);
	logic [15:0] hold_lvl = 16'(RST_HOLD);

	logic [PH_W-1:0]  env_phase = PH_OFF;
	logic [15:0]      env_timer = '0;
	logic [LVL_W-1:0] env_level = '0;

	env_point_t points_due[$];
	env_point_t point_want;
	env_point_t point_seen;
	int         errors = 0;
	int         stall_cycles = 0;
	int         src_idle_pct = 0;
	int         sink_stall_pct = 0;

	timed_adsr_envelope u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [15:0] length_of(input logic [PH_W-1:0] ph);
		case (ph)
			PH_ATTACK: return attack_len;
			PH_DECAY: return decay_len;
			PH_SUSTAIN: return sustain_len;
			PH_RELEASE: return release_len;
			default: return '0;
		endcase
	endfunction

	function automatic logic [31:0] ratio(input logic [31:0] num, input logic [15:0] den);
		return (den == 0) ? '0 : num / den;
	endfunction

	function automatic void advance_envelope(input logic trig, input logic [TICK_W-1:0] ticks);
		logic [15:0] hold;
		logic [15:0] len;
		logic [16:0] sum;
		hold = (hold_lvl > peak_lvl) ? peak_lvl : hold_lvl;
		if (trig) begin
			env_phase = PH_ATTACK;
			env_timer = '0;
		end else if (env_phase != PH_OFF) begin
			sum = {1'b0, env_timer} + 17'(ticks);
			env_timer = sum[16] ? 16'hFFFF : sum[15:0];
			if (env_timer >= length_of(env_phase)) begin
				case (env_phase)
					PH_ATTACK: env_level = peak_lvl;
					PH_DECAY, PH_SUSTAIN: env_level = hold;
					default: env_level = '0;
				endcase
				env_phase = (env_phase >= PH_RELEASE) ? PH_OFF : env_phase + 3'd1;
				env_timer = '0;
			end
			len = length_of(env_phase);
			case (env_phase)
				PH_ATTACK: begin
					env_level = 16'(ratio(32'(env_timer) * 32'(peak_lvl), len));
				end
				PH_DECAY: begin
					env_level = peak_lvl
						- 16'(ratio(32'(peak_lvl - hold) * 32'(env_timer), len));
				end
				PH_RELEASE: begin
					env_level = hold - 16'(ratio(32'(hold) * 32'(env_timer), len));
				end
				default: ;
			endcase
		end
	endfunction

	function automatic logic [15:0] random_length();
		case ($urandom_range(9))
			0: return 16'd1;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(8, 1));
			default: return 16'($urandom_range(1200, 16));
		endcase
	endfunction

	function automatic logic [15:0] random_level();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	function automatic logic [TICK_W-1:0] random_ticks();
		case ($urandom_range(9))
			0, 1, 2: return 8'($urandom_range(15));
			3: return 8'hFF;
			4: return 8'h00;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_request(input logic trig, input logic [TICK_W-1:0] ticks);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= trig;
		s_tdata <= ticks;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		advance_envelope(trig, ticks);
		points_due.push_back('{level: env_level, stage: env_phase});
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (points_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_ATTACK_LEN: attack_len = val;
			REG_DECAY_LEN: decay_len = val;
			REG_SUSTAIN_LEN: sustain_len = val;
			REG_RELEASE_LEN: release_len = val;
			REG_PEAK_LEVEL: peak_lvl = val;
			REG_HOLD_LEVEL: hold_lvl = val;
			default: ;
		endcase
	endtask

	task automatic write_settings(input logic [15:0] a_len, input logic [15:0] d_len,
			input logic [15:0] s_len, input logic [15:0] r_len,
			input logic [15:0] peak, input logic [15:0] hold);
		drain();
		write_register(REG_ATTACK_LEN, a_len);
		write_register(REG_DECAY_LEN, d_len);
		write_register(REG_SUSTAIN_LEN, s_len);
		write_register(REG_RELEASE_LEN, r_len);
		write_register(REG_PEAK_LEVEL, peak);
		write_register(REG_HOLD_LEVEL, hold);
		cfg_we <= 1'b0;
	endtask

	task automatic test_ticks_while_off();
		send_request(1'b0, 8'h00);
		send_request(1'b0, 8'hFF);
	endtask

	task automatic test_default_envelope();
		send_request(1'b1, 8'hA5);
		send_request(1'b0, 8'd0);
		send_request(1'b0, 8'd50);
		send_request(1'b0, 8'd255);
		send_request(1'b0, 8'd30);
		send_request(1'b1, 8'd0);
		send_request(1'b0, 8'd100);
		send_request(1'b0, 8'd100);
		send_request(1'b0, 8'd99);
		send_request(1'b0, 8'd1);
		send_request(1'b0, 8'd50);
		send_request(1'b0, 8'd200);
		send_request(1'b0, 8'd7);
	endtask

	task automatic test_extreme_settings();
		write_settings(16'd1, 16'd1, 16'd1, 16'd1, 16'd1000, 16'hFFFF);
		send_request(1'b1, 8'd0);
		send_request(1'b0, 8'd0);
		send_request(1'b0, 8'd1);
		send_request(1'b0, 8'd1);
		send_request(1'b0, 8'd1);
		send_request(1'b0, 8'd255);
		write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
		send_request(1'b1, 8'd0);
		send_request(1'b0, 8'd255);
		write_settings(16'd3, 16'd3, 16'd3, 16'd3, 16'hFFFF, 16'd0);
		send_request(1'b1, 8'd0);
		send_request(1'b0, 8'd2);
		send_request(1'b0, 8'd1);
		send_request(1'b0, 8'd2);
	endtask

	task automatic test_random_traffic(input int src_pct, input int sink_pct, input int budget);
		int          counted;
		logic        trig;
		logic [15:0] peak;
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		repeat (2) begin
			peak = random_level();
			write_settings(random_length(), random_length(), random_length(),
				random_length(), peak,
				($urandom_range(9) == 0) ? peak : random_level());
			counted = 0;
			while (counted < budget) begin
				if ($urandom_range(99) < 85) begin
					send_request(1'b1, 8'($urandom_range(255)));
					counted++;
					repeat ($urandom_range(40, 1)) begin
						if (env_phase != PH_OFF) counted++;
						send_request(1'b0, random_ticks());
					end
				end else begin
					trig = 1'($urandom_range(1));
					if (trig || env_phase != PH_OFF) counted++;
					send_request(trig, 8'($urandom_range(255)));
				end
			end
		end
	endtask

	task automatic test_timer_saturation();
		src_idle_pct = 6;
		sink_stall_pct = 6;
		write_settings(16'd1, 16'd1, 16'($urandom_range(65535, 65281)),
			16'($urandom_range(300, 1)), random_level(), random_level());
		send_request(1'b1, 8'd0);
		send_request(1'b0, 8'd1);
		send_request(1'b0, 8'd1);
		while (env_phase == PH_SUSTAIN) send_request(1'b0, 8'($urandom_range(255, 200)));
		repeat (8) send_request(1'b0, random_ticks());
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			point_seen.level = m_tdata[LVL_W-1:0];
			point_seen.stage = m_tdata[LVL_W +: PH_W];
			if (points_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual level %0d stage %0d",
					$time, point_seen.level, point_seen.stage);
				errors++;
			end else begin
				point_want = points_due.pop_front();
				if (point_seen.level != point_want.level) begin
					$display("%0t: level mismatch, expected %0d, actual %0d",
						$time, point_want.level, point_seen.level);
					errors++;
				end
				if (point_seen.stage != point_want.stage) begin
					$display("%0t: stage mismatch, expected %0d, actual %0d",
						$time, point_want.stage, point_seen.stage);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no request or result moved for %0d cycles", $time, stall_cycles);
			$display("[timed_adsr_envelope] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_ticks_while_off();
		test_default_envelope();
		test_extreme_settings();
		test_random_traffic(0, 0, 25);
		test_random_traffic(46, 0, 25);
		test_random_traffic(0, 46, 25);
		test_random_traffic(6, 6, 25);
		test_timer_saturation();
		drain();
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("[timed_adsr_envelope] OK");
		end else begin
			$display("[timed_adsr_envelope] ERROR");
		end
		$finish;
	end

endmodule
